FILE: design/chte_pkg.sv
// Shared types and constants of the chained hash table engine.
`default_nettype none
package chte_pkg;

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_UNUSED    = 2'd3
	} status_t;

	localparam logic [31:0] MIX_MUL   = 32'h045d9f3b;
	localparam int          MIX_SHIFT = 16;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] key;
		logic [31:0] value;
	} item_t;

	// Item with its mixed key, as it travels from the hash front to the table back end.
	typedef struct packed {
		item_t       item;
		logic [63:0] hash;
	} qent_t;

endpackage
`default_nettype wire

FILE: design/chte_front.sv
// Hash front: takes transactions and mixes the key over a stalling pipeline.
`default_nettype none
module chte_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire chte_pkg::item_t  in_item,
	output logic                  q_valid,
	input  wire logic             q_stall,
	output chte_pkg::qent_t       q_data
);

	logic adv;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	chte_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic [63:0] h0, r1_s1, a1_s2, p1_s3, r2_s4, a2_s5, p2_s6;
	logic [31:0] hi1_s2, hi2_s5, hi1_mul, hi2_mul;

	assign adv      = !v6_s6 || !q_stall;
	assign in_stall = !adv;
	assign h0       = {{32{in_item.key[31]}}, in_item.key};
	assign hi1_mul  = hi1_s2 * chte_pkg::MIX_MUL;
	assign hi2_mul  = hi2_s5 * chte_pkg::MIX_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= in_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
		end
	end

	// Two rounds, each an xor-shift, then a multiply in two halves (upper half keeps its low word).
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1  <= in_item;
			r1_s1  <= (h0 >> chte_pkg::MIX_SHIFT) ^ h0;
			it_s2  <= it_s1;
			a1_s2  <= 64'(r1_s1[31:0]) * 64'(chte_pkg::MIX_MUL);
			hi1_s2 <= r1_s1[63:32];
			it_s3  <= it_s2;
			p1_s3  <= a1_s2 + {hi1_mul, 32'd0};
			it_s4  <= it_s3;
			r2_s4  <= (p1_s3 >> chte_pkg::MIX_SHIFT) ^ p1_s3;
			it_s5  <= it_s4;
			a2_s5  <= 64'(r2_s4[31:0]) * 64'(chte_pkg::MIX_MUL);
			hi2_s5 <= r2_s4[63:32];
			it_s6  <= it_s5;
			p2_s6  <= a2_s5 + {hi2_mul, 32'd0};
		end
	end

	assign q_valid     = v6_s6;
	assign q_data.item = it_s6;
	assign q_data.hash = (p2_s6 >> chte_pkg::MIX_SHIFT) ^ p2_s6;

endmodule
`default_nettype wire

FILE: design/chte_queue.sv
// Two-entry queue that decouples the hash front from the table back end.
`default_nettype none
module chte_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire chte_pkg::qent_t  in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output chte_pkg::qent_t       out_data
);

	chte_pkg::qent_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

endmodule
`default_nettype wire

FILE: design/chte_back.sv
// Table back end: bucket reduction, chain walk, node pool and result register.
`default_nettype none
module chte_back #(
	parameter int BUCKETS     = 256,
	parameter int NODES       = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_stall,
	input  wire chte_pkg::qent_t  q_data,
	output logic                  init_busy,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output logic [31:0]           old_value,
	output logic [8:0]            entry_count
);

	localparam int BW      = $clog2(BUCKETS);
	localparam int NIW     = $clog2(NODES);
	localparam int NW      = $clog2(NODES + 1);
	localparam int VW      = VALUE_WIDTH;
	localparam bit IS_POW2 = (BUCKETS == (1 << BW));
	localparam logic [NW-1:0] NIL = NW'(NODES);
	// Reciprocal of the bucket count, scaled by 2^32, for the quotient estimate.
	localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

	typedef enum logic [3:0] {
		S_INIT, S_CLR, S_IDLE, S_MOD, S_HEAD, S_HEADW, S_NODE, S_HIT, S_FREE, S_MISS, S_ALLOC
	} state_t;

	state_t state_q;

	// Storage
	logic [NW-1:0] bucket_head [BUCKETS];
	logic [31:0]   node_key    [NODES];
	logic [VW-1:0] node_value  [NODES];
	logic [NW-1:0] node_link   [NODES];

	logic [NW-1:0]  bh_rd, nl_rd;
	logic [31:0]    nk_rd;
	logic [VW-1:0]  nv_rd;
	logic [BW-1:0]  bh_ra, bh_wa;
	logic [NIW-1:0] node_ra, node_wa, nl_wa;
	logic           bh_we, nk_we, nv_we, nl_we;
	logic [NW-1:0]  bh_wd, nl_wd;

	// Working registers
	chte_pkg::cmd_t cmd_q;
	logic [31:0]   key_q;
	logic [VW-1:0] val_q, nv_q;
	logic [63:0]   hash_q;
	logic [BW-1:0] bkt_q, rem_q, idx_q;
	logic [2:0]    cnt_q;
	logic [31:0]   mod_t_q, mod_qe_q;
	logic [NW-1:0] head_q, cur_q, prev_q, nl_q, rec_q, fill_q, total_q;
	logic [1:0]    status_q;
	logic [31:0]   old_q;
	logic [8:0]    count_q;
	logic          out_valid_q;

	logic            start;
	logic [31:0]     mod_t, mod_r;
	logic [63:0]     mod_prod;
	logic [47:0]     mod_back;
	logic [BW-1:0]   rem_nx;
	logic [VW+31:0]  vin_x, vout_x;
	logic [NW+8:0]   total_inc_x, total_dec_x;
	logic [NW-1:0]   total_inc, total_dec;
	logic [NW-1:0]   alloc_node;
	logic            do_insert;

	assign start       = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign q_stall     = !((state_q == S_IDLE) && !out_valid_q);
	assign init_busy   = (state_q == S_INIT);
	// Digit step: partial remainder with the next 16 hash bits, MSB digit first.
	assign mod_t       = 32'({rem_q, hash_q[{cnt_q[2:1], 4'd0} +: 16]});
	assign mod_prod    = 64'(mod_t) * 64'(MOD_RECIP);
	assign mod_back    = 48'(mod_qe_q) * 48'(BUCKETS);
	assign mod_r       = mod_t_q - mod_back[31:0];
	assign rem_nx      = (mod_r >= 32'(BUCKETS)) ? BW'(mod_r - 32'(BUCKETS)) : BW'(mod_r);
	assign vin_x       = {{VW{1'b0}}, q_data.item.value};
	assign vout_x      = {32'd0, nv_q};
	assign total_inc   = total_q + NW'(1);
	assign total_dec   = (total_q != '0) ? total_q - NW'(1) : total_q;
	assign total_inc_x = {9'd0, total_inc};
	assign total_dec_x = {9'd0, total_dec};
	assign alloc_node  = (state_q == S_ALLOC) ? rec_q : fill_q;
	assign do_insert   = (cmd_q == chte_pkg::CMD_PUT) &&
		((state_q == S_ALLOC) || ((state_q == S_MISS) && rec_q == NIL && fill_q != NIL));

	// Memory port control
	always_comb begin
		bh_ra   = bkt_q;
		node_ra = cur_q[NIW-1:0];
		bh_we   = 1'b0;
		bh_wa   = bkt_q;
		bh_wd   = NIL;
		nk_we   = 1'b0;
		nv_we   = 1'b0;
		node_wa = cur_q[NIW-1:0];
		nl_we   = 1'b0;
		nl_wa   = cur_q[NIW-1:0];
		nl_wd   = rec_q;
		unique case (state_q)
			S_INIT, S_CLR: begin
				bh_we = 1'b1;
				bh_wa = idx_q;
			end
			S_HEADW: node_ra = bh_rd[NIW-1:0];
			S_NODE:  node_ra = nl_rd[NIW-1:0];
			S_HIT: begin
				if (cmd_q == chte_pkg::CMD_PUT) begin
					nv_we = 1'b1;
				end else if (cmd_q == chte_pkg::CMD_REMOVE) begin
					if (prev_q == NIL) begin
						bh_we = 1'b1;
						bh_wd = nl_q;
					end else begin
						nl_we = 1'b1;
						nl_wa = prev_q[NIW-1:0];
						nl_wd = nl_q;
					end
				end
			end
			S_FREE: nl_we = 1'b1;
			S_MISS: node_ra = rec_q[NIW-1:0];
			default: ;
		endcase
		if (do_insert) begin
			nk_we   = 1'b1;
			nv_we   = 1'b1;
			node_wa = alloc_node[NIW-1:0];
			nl_we   = 1'b1;
			nl_wa   = alloc_node[NIW-1:0];
			nl_wd   = head_q;
			bh_we   = 1'b1;
			bh_wd   = alloc_node;
		end
	end

	always_ff @(posedge clk) begin
		bh_rd <= bucket_head[bh_ra];
		nk_rd <= node_key[node_ra];
		nv_rd <= node_value[node_ra];
		nl_rd <= node_link[node_ra];
		if (bh_we) bucket_head[bh_wa] <= bh_wd;
		if (nk_we) node_key[node_wa] <= key_q;
		if (nv_we) node_value[node_wa] <= val_q;
		if (nl_we) node_link[nl_wa] <= nl_wd;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			idx_q       <= '0;
			rec_q       <= NIL;
			fill_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			cmd_q       <= chte_pkg::CMD_PUT;
			key_q       <= '0;
			val_q       <= '0;
			hash_q      <= '0;
			bkt_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			mod_t_q     <= '0;
			mod_qe_q    <= '0;
			head_q      <= NIL;
			cur_q       <= NIL;
			prev_q      <= NIL;
			nv_q        <= '0;
			nl_q        <= NIL;
			status_q    <= chte_pkg::STAT_OK;
			old_q       <= '0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT, S_CLR: begin
					idx_q <= idx_q + BW'(1);
					if (idx_q == BW'(BUCKETS - 1)) begin
						idx_q <= '0;
						if (state_q == S_CLR) begin
							out_valid_q <= 1'b1;
							status_q    <= chte_pkg::STAT_OK;
							old_q       <= '0;
							count_q     <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q  <= q_data.item.cmd;
						key_q  <= q_data.item.key;
						val_q  <= vin_x[VW-1:0];
						hash_q <= q_data.hash;
						bkt_q  <= q_data.hash[BW-1:0];
						rem_q  <= '0;
						cnt_q  <= 3'd7;
						if (q_data.item.cmd == chte_pkg::CMD_CLEAR) begin
							rec_q   <= NIL;
							fill_q  <= '0;
							total_q <= '0;
							idx_q   <= '0;
							state_q <= S_CLR;
						end else if (IS_POW2) begin
							state_q <= S_HEAD;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					// For each 16-bit digit: first estimate the quotient by reciprocal
					// multiply, then subtract it back and correct by one bucket count.
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q[0]) begin
						mod_t_q  <= mod_t;
						mod_qe_q <= mod_prod[63:32];
					end else begin
						rem_q <= rem_nx;
						if (cnt_q == 3'd0) begin
							bkt_q   <= rem_nx;
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					head_q <= bh_rd;
					cur_q  <= bh_rd;
					prev_q <= NIL;
					state_q <= (bh_rd == NIL) ? S_MISS : S_NODE;
				end
				S_NODE: begin
					if (nk_rd == key_q) begin
						nv_q    <= nv_rd;
						nl_q    <= nl_rd;
						state_q <= S_HIT;
					end else begin
						prev_q <= cur_q;
						cur_q  <= nl_rd;
						if (nl_rd == NIL) state_q <= S_MISS;
					end
				end
				S_HIT: begin
					status_q <= chte_pkg::STAT_OK;
					old_q    <= vout_x[31:0];
					if (cmd_q == chte_pkg::CMD_REMOVE) begin
						state_q <= S_FREE;
					end else begin
						out_valid_q <= 1'b1;
						count_q     <= total_inc_x[8:0] - 9'd1;
						state_q     <= S_IDLE;
					end
				end
				S_FREE: begin
					rec_q       <= cur_q;
					total_q     <= total_dec;
					count_q     <= total_dec_x[8:0];
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_MISS: begin
					old_q <= '0;
					if (cmd_q != chte_pkg::CMD_PUT) begin
						status_q    <= chte_pkg::STAT_NOT_FOUND;
						count_q     <= total_inc_x[8:0] - 9'd1;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (rec_q != NIL) begin
						state_q <= S_ALLOC;
					end else if (fill_q != NIL) begin
						fill_q      <= fill_q + NW'(1);
						total_q     <= total_inc;
						status_q    <= chte_pkg::STAT_OK;
						count_q     <= total_inc_x[8:0];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						status_q    <= chte_pkg::STAT_FULL;
						count_q     <= total_inc_x[8:0] - 9'd1;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_ALLOC: begin
					rec_q       <= nl_rd;
					total_q     <= total_inc;
					status_q    <= chte_pkg::STAT_OK;
					count_q     <= total_inc_x[8:0];
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign old_value   = old_q;
	assign entry_count = count_q;

`ifndef NO_ASSERTIONS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= NIL) else $error("entry total beyond pool size");
	a_pop_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !q_stall) |-> !out_valid_q) else $error("item taken while result pending");
	a_recycled_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_q != NIL) |-> (rec_q < fill_q)) else $error("recycled node never allocated");
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> (q_stall && !out_valid_q)) else $error("activity during init");
`endif

endmodule
`default_nettype wire

FILE: design/chained_hash_table_engine_core.sv
// Top level of the chained hash table engine.
`default_nettype none
// Key-value table with separate chaining over a fixed pool of NODES nodes and
// BUCKETS buckets. Each input transaction carries a command (put, get, remove,
// clear), a signed key and a value; each yields exactly one result transaction
// with status, the value read, replaced or removed, and the entry count after it.
// After reset the block sweeps all bucket heads with in_stall high; a clear
// command runs the same sweep before it answers. A key goes through a six-stage
// hash pipeline, then a two-entry queue into the table sequencer. Within the
// sequencer get and put-update walk the bucket's chain, one node per cycle
// through the node memory read port; remove adds a free state, and put of a new
// key adds an allocate state when it takes a recycled node and none when it
// takes a never-used one. The next transaction starts only after the result
// register has been taken. When BUCKETS is not a power of two the bucket
// reduction adds an estimate step and a correction step per 16-bit hash digit.
// Results sit in an output register, so the front keeps accepting until the hash
// pipeline and the queue are full while a result waits for out_stall to drop.
module chained_hash_table_engine_core #(
	parameter int BUCKETS     = 256,
	parameter int NODES       = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic signed [31:0] key,
	input  wire logic [31:0]        value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [31:0]             old_value,
	output logic [8:0]              entry_count
);

	chte_pkg::item_t in_item;
	chte_pkg::qent_t fq_data, qb_data;
	logic front_stall, init_busy, front_valid;
	logic fq_valid, fq_stall, qb_valid, qb_stall;

	assign in_item.cmd   = chte_pkg::cmd_t'(command);
	assign in_item.key   = key;
	assign in_item.value = value;

	// Hold off all input transactions during the post-reset sweep.
	assign front_valid = in_valid && !init_busy;
	assign in_stall    = front_stall || init_busy;

	chte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_stall (front_stall),
		.in_item  (in_item),
		.q_valid  (fq_valid),
		.q_stall  (fq_stall),
		.q_data   (fq_data)
	);

	chte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_stall  (fq_stall),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_stall (qb_stall),
		.out_data  (qb_data)
	);

	chte_back #(
		.BUCKETS     (BUCKETS),
		.NODES       (NODES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (qb_valid),
		.q_stall     (qb_stall),
		.q_data      (qb_data),
		.init_busy   (init_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.old_value   (old_value),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire

FILE: dv/chained_hash_table_engine_core_tb.sv
// Self-checking testbench for the chained hash table engine core.
`default_nettype none
module chained_hash_table_engine_core_tb;

	localparam int BUCKETS   = 256;
	localparam int NODES     = 256;
	localparam int NIL       = NODES;
	localparam int WDOG_MAX  = 20000;
	localparam int DIR_ROWS  = 20;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        command;
	logic signed [31:0] key;
	logic [31:0]       value;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [31:0]       old_value;
	logic [8:0]        entry_count;

	chained_hash_table_engine_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .key(key), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .old_value(old_value), .entry_count(entry_count)
	);

	typedef struct packed {
		chte_pkg::status_t st;
		logic [31:0]       old;
		logic [8:0]        cnt;
	} answer_t;

	// Mirror of the table state.
	int unsigned tbl_head [BUCKETS];
	logic [31:0] tbl_key  [NODES];
	logic [31:0] tbl_val  [NODES];
	int unsigned tbl_link [NODES];
	int unsigned tbl_free;
	int unsigned tbl_total;

	answer_t     answers_due [$];
	int          fails;
	int          wdog;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic [31:0] key_pool [16];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int unsigned bucket_index(logic [31:0] k);
		logic [63:0] h;
		h = {{32{k[31]}}, k};
		h = ((h >> chte_pkg::MIX_SHIFT) ^ h) * 64'(chte_pkg::MIX_MUL);
		h = ((h >> chte_pkg::MIX_SHIFT) ^ h) * 64'(chte_pkg::MIX_MUL);
		h = (h >> chte_pkg::MIX_SHIFT) ^ h;
		return int'(h % BUCKETS);
	endfunction

	function automatic void table_rebuild();
		for (int i = 0; i < BUCKETS; i++) tbl_head[i] = NIL;
		for (int i = 0; i < NODES; i++) tbl_link[i] = i + 1;
		tbl_free  = 0;
		tbl_total = 0;
	endfunction

	// Apply one transaction to the mirror and return the answer it must produce.
	function automatic answer_t table_apply(chte_pkg::cmd_t c, logic [31:0] k,
			logic [31:0] v);
		answer_t     a;
		int unsigned b, prev, n, steps, f;
		logic        hit;
		a = '{chte_pkg::STAT_OK, 32'd0, 9'd0};
		if (c == chte_pkg::CMD_CLEAR) begin
			table_rebuild();
		end else begin
			b = bucket_index(k);
			prev = NIL;
			n = tbl_head[b];
			steps = 0;
			while (n < NIL && steps < NODES && tbl_key[n] != k) begin
				prev = n;
				n = tbl_link[n];
				steps++;
			end
			hit = (n < NIL) && (steps < NODES);
			if (c == chte_pkg::CMD_PUT) begin
				if (hit) begin
					a.old = tbl_val[n];
					tbl_val[n] = v;
				end else if (tbl_free >= NIL) begin
					a.st = chte_pkg::STAT_FULL;
				end else begin
					f = tbl_free;
					tbl_free = tbl_link[f];
					tbl_key[f] = k;
					tbl_val[f] = v;
					tbl_link[f] = tbl_head[b];
					tbl_head[b] = f;
					tbl_total++;
				end
			end else if (!hit) begin
				a.st = chte_pkg::STAT_NOT_FOUND;
			end else if (c == chte_pkg::CMD_GET) begin
				a.old = tbl_val[n];
			end else begin
				a.old = tbl_val[n];
				if (prev < NIL) tbl_link[prev] = tbl_link[n];
				else tbl_head[b] = tbl_link[n];
				tbl_link[n] = tbl_free;
				tbl_free = n;
				if (tbl_total > 0) tbl_total--;
			end
		end
		a.cnt = 9'(tbl_total);
		return a;
	endfunction

	// Directed rows: command, key, value, whether an answer is typed in, and that answer.
	typedef struct packed {
		chte_pkg::cmd_t c;
		logic [31:0]    k;
		logic [31:0]    v;
		logic           typed;
		answer_t        ans;
	} row_t;

	row_t dir_rows [DIR_ROWS] = '{
		'{chte_pkg::CMD_GET,    32'h0000_0000, 32'h0,         1'b1,
			'{chte_pkg::STAT_NOT_FOUND, 32'h0, 9'd0}},
		'{chte_pkg::CMD_REMOVE, 32'h8000_0000, 32'h0,         1'b1,
			'{chte_pkg::STAT_NOT_FOUND, 32'h0, 9'd0}},
		'{chte_pkg::CMD_PUT,    32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd1}},
		'{chte_pkg::CMD_PUT,    32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd2}},
		'{chte_pkg::CMD_PUT,    32'hFFFF_FFFF, 32'hAAAA_5555, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd3}},
		'{chte_pkg::CMD_PUT,    32'h0000_0000, 32'h5555_AAAA, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd4}},
		'{chte_pkg::CMD_GET,    32'h8000_0000, 32'h1234_5678, 1'b1,
			'{chte_pkg::STAT_OK, 32'hFFFF_FFFF, 9'd4}},
		'{chte_pkg::CMD_PUT,    32'h8000_0000, 32'h0000_0001, 1'b1,
			'{chte_pkg::STAT_OK, 32'hFFFF_FFFF, 9'd4}},
		'{chte_pkg::CMD_GET,    32'h8000_0000, 32'h0,         1'b1,
			'{chte_pkg::STAT_OK, 32'h1, 9'd4}},
		'{chte_pkg::CMD_GET,    32'h0000_0001, 32'h0,         1'b1,
			'{chte_pkg::STAT_NOT_FOUND, 32'h0, 9'd4}},
		'{chte_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd3}},
		'{chte_pkg::CMD_GET,    32'h7FFF_FFFF, 32'h0,         1'b1,
			'{chte_pkg::STAT_NOT_FOUND, 32'h0, 9'd3}},
		'{chte_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b1,
			'{chte_pkg::STAT_OK, 32'hAAAA_5555, 9'd2}},
		'{chte_pkg::CMD_PUT,    32'h0000_0100, 32'h0000_0100, 1'b0,
			'{chte_pkg::STAT_OK, 32'h0, 9'd0}},
		'{chte_pkg::CMD_PUT,    32'hFFFF_FF00, 32'h8000_0000, 1'b0,
			'{chte_pkg::STAT_OK, 32'h0, 9'd0}},
		'{chte_pkg::CMD_CLEAR,  32'h1234_5678, 32'h8765_4321, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd0}},
		'{chte_pkg::CMD_GET,    32'h0000_0000, 32'h0,         1'b1,
			'{chte_pkg::STAT_NOT_FOUND, 32'h0, 9'd0}},
		'{chte_pkg::CMD_REMOVE, 32'h0000_0100, 32'h0,         1'b1,
			'{chte_pkg::STAT_NOT_FOUND, 32'h0, 9'd0}},
		'{chte_pkg::CMD_PUT,    32'h0000_0000, 32'h0000_0007, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd1}},
		'{chte_pkg::CMD_CLEAR,  32'h0,         32'h0,         1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd0}}
	};

	// Drive one transaction: hold valid and payload until it is accepted at a rising edge.
	// Valid stays high between back-to-back transactions; a random sender gap drops it
	// first, and the gap is decided ahead of valid so valid never depends on stall.
	task automatic send_item(chte_pkg::cmd_t c, logic [31:0] k, logic [31:0] v,
			logic typed, answer_t typed_ans);
		answer_t a;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= c;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (in_stall);
		a = table_apply(c, k, v);
		if (typed && a != typed_ans)
			$display("%0t: table mirror disagrees with typed answer %p vs %p",
				$time, typed_ans, a);
		answers_due.push_back(typed ? typed_ans : a);
		@(negedge clk);
	endtask

	// Pick a key: mostly from a small pool so puts, gets and removes collide.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(99) < 80) return key_pool[$urandom_range(15)];
		return $urandom();
	endfunction

	task automatic send_random(int count, int full_bias);
		chte_pkg::cmd_t c;
		int             r;
		logic [31:0]    k;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (full_bias) begin
				c = (r < 95) ? chte_pkg::CMD_PUT :
					(r < 98) ? chte_pkg::CMD_GET : chte_pkg::CMD_REMOVE;
				k = $urandom();
			end else begin
				c = (r < 40) ? chte_pkg::CMD_PUT : (r < 70) ? chte_pkg::CMD_GET :
					(r < 98) ? chte_pkg::CMD_REMOVE : chte_pkg::CMD_CLEAR;
				k = pick_key();
			end
			send_item(c, k, $urandom(), 1'b0, '0);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (answers_due.size() > 0) @(negedge clk);
	endtask

	// Receiver: random stall, check every result against the oldest answer due.
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result status=%0d old=%h count=%0d",
					$time, status, old_value, entry_count);
				fails++;
			end else begin
				exp_a = answers_due.pop_front();
				if (status !== exp_a.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_a.st, status);
					fails++;
				end
				if (old_value !== exp_a.old) begin
					$display("%0t: old_value expected %h actual %h", $time, exp_a.old, old_value);
					fails++;
				end
				if (entry_count !== exp_a.cnt) begin
					$display("%0t: entry_count expected %0d actual %0d",
						$time, exp_a.cnt, entry_count);
					fails++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		fails          = 0;
		wdog           = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		out_stall      = 1'b0;
		command        = chte_pkg::CMD_PUT;
		key            = '0;
		value          = '0;
		for (int i = 0; i < NODES; i++) begin
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end
		table_rebuild();
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows, no idling.
		foreach (dir_rows[i])
			send_item(dir_rows[i].c, dir_rows[i].k, dir_rows[i].v,
				dir_rows[i].typed, dir_rows[i].ans);

		// Fill the pool past full, then empty it with a clear.
		send_random(300, 1);
		drain();
		send_item(chte_pkg::CMD_CLEAR, 32'h0, 32'h0, 1'b1,
			'{chte_pkg::STAT_OK, 32'h0, 9'd0});

		// Random phases with the idling mixes; pause once for all results after the second.
		send_random(300, 0);
		send_idle_pct = 45;
		send_random(300, 0);
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 45;
		send_random(300, 0);
		send_idle_pct  = 25;
		recv_stall_pct = 25;
		send_random(300, 0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		drain();
		repeat (50) @(posedge clk);
		if (fails == 0 && answers_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
